// File: design/double_ended_queue_defines.svh
// ----------------------------------------------------------------------------
// double_ended_queue_defines
// Assertion macros shared by the deque RTL.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, masked during reset.
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, masked during reset.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Sizes, request codes, state encoding and ring arithmetic for the deque.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int REQ_W   = 3;
    localparam int OCNT_W  = 11;

    localparam logic [ADDR_W:0] DEPTH_EXT = (ADDR_W + 1)'(DEPTH);

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_QUERY      = 3'd4
    } req_code_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } deq_state_t;

    // (a + b) mod DEPTH for a, b < DEPTH
    function automatic logic [ADDR_W-1:0] slot_add(
        input logic [ADDR_W-1:0] a,
        input logic [ADDR_W-1:0] b
    );
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_EXT)
        begin
            s = s - DEPTH_EXT;
        end
        return s[ADDR_W-1:0];
    endfunction

    // (a - 1) mod DEPTH
    function automatic logic [ADDR_W-1:0] slot_dec(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        if (a == '0)
        begin
            r = ADDR_W'(DEPTH - 1);
        end
        else
        begin
            r = a - ADDR_W'(1);
        end
        return r;
    endfunction

endpackage

// File: design/deq_req_if.sv
// ----------------------------------------------------------------------------
// deq_req_if
// Request channel: valid/ready handshake with request code and push word.
// ----------------------------------------------------------------------------
interface deq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic        [deq_pkg::REQ_W-1:0]     req_type;
    logic signed [deq_pkg::DATA_W-1:0]    push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

// File: design/deq_rsp_if.sv
// ----------------------------------------------------------------------------
// deq_rsp_if
// Response channel: valid/ready handshake with one result per request.
// ----------------------------------------------------------------------------
interface deq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [deq_pkg::DATA_W-1:0]    popped_value;
    logic                                 popped_valid;
    logic signed [deq_pkg::DATA_W-1:0]    front_value;
    logic signed [deq_pkg::DATA_W-1:0]    back_value;
    logic        [deq_pkg::OCNT_W-1:0]    item_count;
    logic                                 is_empty;
    logic                                 push_dropped;

    modport source (
        output valid, output popped_value, output popped_valid, output front_value,
        output back_value, output item_count, output is_empty, output push_dropped,
        input ready
    );
    modport sink (
        input valid, input popped_value, input popped_valid, input front_value,
        input back_value, input item_count, input is_empty, input push_dropped,
        output ready
    );
endinterface

// File: design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words kept in a ring memory.
// ----------------------------------------------------------------------------
// Usage:
//   req : push front / push back / pop front / pop back / query, with a word.
//   rsp : one transfer per request: popped word and flag, front and back word,
//         count and empty flag after the request, and a dropped-push flag.
//   Words live in a 1024 x 32 synchronous RAM (one write or one read port
//   used per request). The two end words are also held in registers, so
//   pushes, queries and pops that leave at most one word finish at once.
//   Result is registered, valid in the cycle after the request transfer;
//   a pop that leaves two or more words first goes through ST_READ, since
//   the newly exposed end word is fetched from the RAM (registered read).
//   Throughput: one request per cycle while rsp is taken and no fetch runs.
//   The result sits in an output register; a new request is taken in the
//   same cycle the pending result transfers. If the receiver stalls, ready
//   on req drops until rsp is taken; nothing is lost.
//   Reset (rst_n low, async): queue empty, head at slot 0, no result
//   pending. RAM contents are not cleared; only written slots are read.
//   Pop on empty returns popped_valid = 0; push on full is dropped and
//   flagged. Unused request codes act as a query.
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module double_ended_queue (
    input  logic      clk,
    input  logic      rst_n,
    deq_req_if.sink   req,
    deq_rsp_if.source rsp
);

    // Ring storage
    logic [deq_pkg::DATA_W-1:0] ring_mem [deq_pkg::DEPTH];
    logic [deq_pkg::DATA_W-1:0] rdata_reg;
    logic                       mem_we;
    logic                       mem_re;
    logic [deq_pkg::ADDR_W-1:0] mem_waddr;
    logic [deq_pkg::ADDR_W-1:0] mem_raddr;

    // Queue control state
    deq_pkg::deq_state_t        state_reg, state_next;
    logic [deq_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [deq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       out_valid_reg, out_valid_next;

    // End-word cache and result payload
    logic [deq_pkg::DATA_W-1:0] front_reg, front_next;
    logic [deq_pkg::DATA_W-1:0] back_reg, back_next;
    logic [deq_pkg::DATA_W-1:0] popped_reg, popped_next;
    logic                       pvalid_reg, pvalid_next;
    logic                       dropped_reg, dropped_next;
    logic                       fix_back_reg, fix_back_next;  // refill target of the read

    logic                       in_fire;
    logic                       need_read;
    logic                       is_full;
    logic [31:0]                count_wide;
    deq_pkg::req_code_t         code;

    assign code      = deq_pkg::req_code_t'(req.req_type);
    assign is_full   = (count_reg == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    // Only one item in flight; accept when the result slot is free or draining.
    assign req.ready = (state_reg == deq_pkg::ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign in_fire   = req.valid && req.ready;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        popped_next    = popped_reg;
        pvalid_next    = pvalid_reg;
        dropped_next   = dropped_reg;
        fix_back_next  = fix_back_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = head_reg;
        mem_raddr      = head_reg;
        need_read      = 1'b0;

        unique case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    popped_next   = '0;
                    pvalid_next   = 1'b0;
                    dropped_next  = 1'b0;
                    fix_back_next = 1'b0;
                    unique case (code)
                        deq_pkg::REQ_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                head_next  = deq_pkg::slot_dec(head_reg);
                                mem_we     = 1'b1;
                                mem_waddr  = deq_pkg::slot_dec(head_reg);
                                front_next = req.push_value;
                                if (count_reg == '0)
                                begin
                                    back_next = req.push_value;
                                end
                                count_next = count_reg + deq_pkg::CNT_W'(1);
                            end
                        end
                        deq_pkg::REQ_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = deq_pkg::slot_add(head_reg,
                                                deq_pkg::ADDR_W'(count_reg));
                                back_next = req.push_value;
                                if (count_reg == '0)
                                begin
                                    front_next = req.push_value;
                                end
                                count_next = count_reg + deq_pkg::CNT_W'(1);
                            end
                        end
                        deq_pkg::REQ_POP_FRONT:
                        begin
                            if (count_reg != '0)
                            begin
                                popped_next = front_reg;
                                pvalid_next = 1'b1;
                                head_next   = deq_pkg::slot_add(head_reg,
                                                  deq_pkg::ADDR_W'(1));
                                count_next  = count_reg - deq_pkg::CNT_W'(1);
                                if (count_reg == deq_pkg::CNT_W'(2))
                                begin
                                    front_next = back_reg;
                                end
                                else if (count_reg > deq_pkg::CNT_W'(2))
                                begin
                                    // new front is the slot after the old head
                                    mem_re    = 1'b1;
                                    mem_raddr = deq_pkg::slot_add(head_reg,
                                                    deq_pkg::ADDR_W'(1));
                                    need_read = 1'b1;
                                end
                            end
                        end
                        deq_pkg::REQ_POP_BACK:
                        begin
                            if (count_reg != '0)
                            begin
                                popped_next = back_reg;
                                pvalid_next = 1'b1;
                                count_next  = count_reg - deq_pkg::CNT_W'(1);
                                if (count_reg == deq_pkg::CNT_W'(2))
                                begin
                                    back_next = front_reg;
                                end
                                else if (count_reg > deq_pkg::CNT_W'(2))
                                begin
                                    // new back sits at position count-2
                                    mem_re        = 1'b1;
                                    mem_raddr     = deq_pkg::slot_add(head_reg,
                                        deq_pkg::ADDR_W'(count_reg - deq_pkg::CNT_W'(2)));
                                    need_read     = 1'b1;
                                    fix_back_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            // query and unused codes: no change
                        end
                    endcase

                    if (need_read)
                    begin
                        state_next = deq_pkg::ST_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            deq_pkg::ST_READ:
            begin
                // RAM word is in rdata_reg; refill the cached end and publish
                if (fix_back_reg)
                begin
                    back_next = rdata_reg;
                end
                else
                begin
                    front_next = rdata_reg;
                end
                out_valid_next = 1'b1;
                state_next     = deq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase
    end

    // Synchronous RAM, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= front_next & '0 | (mem_we ? req.push_value : '0);
        end
        if (mem_re)
        begin
            rdata_reg <= ring_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deq_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg    <= front_next;
        back_reg     <= back_next;
        popped_reg   <= popped_next;
        pvalid_reg   <= pvalid_next;
        dropped_reg  <= dropped_next;
        fix_back_reg <= fix_back_next;
    end

    // Result fields come straight from state; it holds while the result waits.
    assign count_wide       = 32'(count_reg);
    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_value = popped_reg;
    assign rsp.popped_valid = pvalid_reg;
    assign rsp.front_value  = (count_reg == '0) ? '0 : front_reg;
    assign rsp.back_value   = (count_reg == '0) ? '0 : back_reg;
    assign rsp.item_count   = count_wide[deq_pkg::OCNT_W-1:0];
    assign rsp.is_empty     = (count_reg == '0);
    assign rsp.push_dropped = dropped_reg;

    // Occupancy never passes the ring size.
    `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= deq_pkg::CNT_W'(deq_pkg::DEPTH), "count over depth")
    // The result slot is always free while a RAM fetch is outstanding.
    `DEQ_ASSERT_NOW(a_read_slot_free, state_reg == deq_pkg::ST_READ, !out_valid_reg, "result slot busy during fetch")
    // A fetch always completes into a published result.
    `DEQ_ASSERT_NEXT(a_read_publishes, state_reg == deq_pkg::ST_READ, out_valid_reg && state_reg == deq_pkg::ST_IDLE, "fetch did not publish")

endmodule
